// ===== design/mspt_pkg.sv =====
// shared types and constants for the multichannel spike and peak tally
`timescale 1ns / 1ps

package mspt_pkg;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_RUN_LENGTH = 2'd1;
  localparam logic [1:0] REG_ACTIVE_CH  = 2'd2;

  localparam logic       MODE_RESET       = 1'b0;
  localparam logic [7:0] RUN_LENGTH_RESET = 8'd5;
  localparam logic [9:0] ACTIVE_CH_RESET  = 10'd384;

  localparam logic [8:0]        RUN_MAX   = 9'd511;
  localparam logic signed [15:0] MIN_RESET = 16'sh7fff;
  localparam logic signed [15:0] MAX_RESET = 16'sh8000;

  typedef struct packed {
    logic [1:0]         action;
    logic [8:0]         channel;
    logic signed [15:0] sample;
    logic               first_in_block;
    logic signed [15:0] threshold;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        spike_count;
    logic signed [15:0] minimum;
    logic signed [15:0] maximum;
    logic               spike_now;
  } result_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] run_length;
    logic [9:0] active_channels;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic sweep_we;
    logic clr_done;
  } cmd_t;

endpackage

// ===== design/mspt_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module mspt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mspt_ctrl.sv =====
// controller state machine: item sequencing and store clearing sweeps
`timescale 1ns / 1ps

module mspt_ctrl #(
  parameter int NUM_CHANNELS = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          action_i,
  output logic                busy_o,
  output mspt_pkg::cmd_t      cmd_o,
  output logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] sweep_addr_o
);

  localparam int AW = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } state_e;

  state_e        state_q;
  logic [AW-1:0] cnt_q;
  logic          busy_q;
  logic          last;

  assign last = cnt_q == AW'(NUM_CHANNELS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      busy_q  <= 1'b1;
    end else begin
      unique case (state_q)
        ST_INIT, ST_CLEAR: begin
          if (last) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (start_i) begin
            busy_q <= 1'b1;
            if (action_i == mspt_pkg::ACT_CLEAR) begin
              state_q <= ST_CLEAR;
            end else begin
              state_q <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.accept   = (state_q == ST_IDLE) && start_i;
    cmd_o.exec     = state_q == ST_EXEC;
    cmd_o.sweep_we = (state_q == ST_INIT) || (state_q == ST_CLEAR);
    cmd_o.clr_done = (state_q == ST_CLEAR) && last;
  end

  assign busy_o       = busy_q;
  assign sweep_addr_o = cnt_q;

endmodule

// ===== design/mspt_datapath.sv =====
// datapath: channel store read-modify-write, spike and peak update, result register
`timescale 1ns / 1ps

module mspt_datapath #(
  parameter int NUM_CHANNELS = 512,
  parameter int COUNT_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mspt_pkg::cmd_t      cmd_i,
  input  logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] sweep_addr_i,
  input  mspt_pkg::cfg_t      cfg_i,
  input  mspt_pkg::in_item_t  item_i,
  output logic                done_o,
  output mspt_pkg::result_t   result_o
);

  localparam int AW   = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
  localparam int WW   = 9 + COUNT_BITS + 32;
  localparam int EXTW = COUNT_BITS > 32 ? COUNT_BITS : 32;

  mspt_pkg::in_item_t item_q;
  mspt_pkg::result_t  res_q;
  logic               done_q;

  logic [WW-1:0]         st_rdata;
  logic [WW-1:0]         st_wdata;
  logic [WW-1:0]         new_word;
  logic                  st_we;
  logic [AW-1:0]         st_waddr;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         item_addr;
  logic [15:0]           thr_rdata;
  logic                  thr_we;

  logic [8:0]            rd_run;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic signed [15:0]    rd_min;
  logic signed [15:0]    rd_max;
  logic [8:0]            run_new;
  logic [COUNT_BITS-1:0] cnt_new;
  logic signed [15:0]    min_new;
  logic signed [15:0]    max_new;
  logic                  ch_valid;
  logic                  ch_active;
  logic                  is_sample;
  logic                  low;
  logic                  spike;
  logic [EXTW-1:0]       cnt_ext;
  mspt_pkg::result_t     res_d;

  assign raddr     = AW'(item_i.channel);
  assign item_addr = AW'(item_q.channel);

  assign {rd_run, rd_cnt, rd_min, rd_max} = st_rdata;

  assign ch_valid  = 32'(item_q.channel) < 32'(NUM_CHANNELS);
  assign ch_active = {1'b0, item_q.channel} < cfg_i.active_channels;
  assign is_sample = (item_q.action == mspt_pkg::ACT_SAMPLE) && ch_valid && ch_active;
  assign low       = item_q.sample <= $signed(thr_rdata);

  always_comb begin
    run_new = rd_run;
    spike   = 1'b0;
    if (item_q.first_in_block) begin
      run_new = low ? {1'b0, cfg_i.run_length} : 9'd0;
    end else if (low) begin
      if (rd_run != mspt_pkg::RUN_MAX) begin
        run_new = rd_run + 9'd1;
        spike   = run_new == {1'b0, cfg_i.run_length};
      end
    end else begin
      run_new = 9'd0;
    end
  end

  assign cnt_new = (spike && (rd_cnt != '1)) ? rd_cnt + COUNT_BITS'(1) : rd_cnt;
  assign min_new = (item_q.sample < rd_min) ? item_q.sample : rd_min;
  assign max_new = (item_q.sample > rd_max) ? item_q.sample : rd_max;

  always_comb begin
    new_word = st_rdata;
    if (is_sample) begin
      if (cfg_i.mode) begin
        new_word = {rd_run, rd_cnt, min_new, max_new};
      end else begin
        new_word = {run_new, cnt_new, rd_min, rd_max};
      end
    end
  end

  assign st_we    = cmd_i.sweep_we || (cmd_i.exec && is_sample);
  assign st_waddr = cmd_i.sweep_we ? sweep_addr_i : item_addr;
  assign st_wdata = cmd_i.sweep_we
                    ? {9'd0, COUNT_BITS'(0), mspt_pkg::MIN_RESET, mspt_pkg::MAX_RESET}
                    : new_word;

  assign thr_we = cmd_i.exec && (item_q.action == mspt_pkg::ACT_LOAD) && ch_valid;

  mspt_ram #(
    .WIDTH (WW),
    .DEPTH (NUM_CHANNELS)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (raddr),
    .rdata_o (st_rdata)
  );

  mspt_ram #(
    .WIDTH (16),
    .DEPTH (NUM_CHANNELS)
  ) u_thr_ram (
    .clk_i   (clk_i),
    .we_i    (thr_we),
    .waddr_i (item_addr),
    .wdata_i (item_q.threshold),
    .raddr_i (raddr),
    .rdata_o (thr_rdata)
  );

  assign cnt_ext = EXTW'(new_word[WW-10 -: COUNT_BITS]);

  always_comb begin
    if (ch_valid) begin
      res_d.spike_count = cnt_ext[31:0];
      res_d.minimum     = new_word[31:16];
      res_d.maximum     = new_word[15:0];
      res_d.spike_now   = is_sample && !cfg_i.mode && spike;
    end else begin
      res_d.spike_count = 32'd0;
      res_d.minimum     = mspt_pkg::MIN_RESET;
      res_d.maximum     = mspt_pkg::MAX_RESET;
      res_d.spike_now   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= item_i;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end else if (cmd_i.clr_done) begin
      res_q.spike_count <= 32'd0;
      res_q.minimum     <= mspt_pkg::MIN_RESET;
      res_q.maximum     <= mspt_pkg::MAX_RESET;
      res_q.spike_now   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.exec || cmd_i.clr_done;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== design/multichannel_spike_and_peak_tally.sv =====
// top level: configuration registers, controller and datapath
// an item is accepted when start is high and busy is low
// sample, threshold and other non-clear items: result strobe after the execute state
// clear items: sweep over every address of the channel store ram, result at its end
// after reset the same sweep runs with busy high throughout
// busy covers the registered store ram read and its write back, so items never overlap
`timescale 1ns / 1ps

module multichannel_spike_and_peak_tally #(
  parameter int NUM_CHANNELS = 512,
  parameter int COUNT_BITS   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mspt_pkg::in_item_t item_i,
  output logic               done_o,
  output mspt_pkg::result_t  result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;

  logic           mode_q;
  logic [7:0]     run_len_q;
  logic [9:0]     act_ch_q;
  logic           wr_en;
  mspt_pkg::cfg_t cfg;
  mspt_pkg::cmd_t cmd;
  logic [AW-1:0]  sweep_addr;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= mspt_pkg::MODE_RESET;
      run_len_q <= mspt_pkg::RUN_LENGTH_RESET;
      act_ch_q  <= mspt_pkg::ACTIVE_CH_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        mspt_pkg::REG_MODE:       mode_q    <= pwdata[0];
        mspt_pkg::REG_RUN_LENGTH: run_len_q <= pwdata[7:0];
        mspt_pkg::REG_ACTIVE_CH:  act_ch_q  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mspt_pkg::REG_MODE:       prdata = {31'd0, mode_q};
      mspt_pkg::REG_RUN_LENGTH: prdata = {24'd0, run_len_q};
      mspt_pkg::REG_ACTIVE_CH:  prdata = {22'd0, act_ch_q};
      default:                  prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.mode            = mode_q;
    cfg.run_length      = run_len_q;
    cfg.active_channels = act_ch_q;
  end

  mspt_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .action_i     (item_i.action),
    .busy_o       (busy),
    .cmd_o        (cmd),
    .sweep_addr_o (sweep_addr)
  );

  mspt_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sweep_addr_i (sweep_addr),
    .cfg_i        (cfg),
    .item_i       (item_i),
    .done_o       (done_o),
    .result_o     (result_o)
  );

endmodule

// ===== design/mspt_checker.sv =====
// port-level checker for the multichannel spike and peak tally, with its bind
`timescale 1ns / 1ps

module mspt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input mspt_pkg::in_item_t item_i,
  input logic               done_o
);

  logic accept;
  assign accept = start && !busy;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after accepted item");

  a_short_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.action != mspt_pkg::ACT_CLEAR) |-> ##2 done_o)
    else $error("missing result two cycles after item");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

endmodule

bind multichannel_spike_and_peak_tally mspt_checker u_mspt_checker (.*);

// ===== sim/mspt_tally_checker.sv =====
// checker for the spike and peak tally: tracks registers, predicts each result, compares
`timescale 1ns / 1ps

module mspt_tally_checker
  import mspt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  in_item_t    item_i,
  input  logic        done_i,
  input  result_t     result_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic [31:0] prdata_i,
  input  logic        pready_i,
  output int          err_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          spikes_o
);

  localparam int   CHANNELS   = 512;
  localparam logic MODE_SPIKE = 1'b0;

  logic              mode;
  logic [7:0]        run_len;
  logic [9:0]        act_ch;
  logic [8:0]        run_cnt [CHANNELS];
  logic [31:0]       totals  [CHANNELS];
  logic signed [15:0] ch_lo  [CHANNELS];
  logic signed [15:0] ch_hi  [CHANNELS];
  logic signed [15:0] ch_thr [CHANNELS];
  result_t           expected_tallies [$];
  result_t           want;
  logic [31:0]       reg_val;

  function automatic void wipe_tallies();
    for (int i = 0; i < CHANNELS; i++) begin
      run_cnt[i] = '0;
      totals[i]  = '0;
      ch_lo[i]   = MIN_RESET;
      ch_hi[i]   = MAX_RESET;
    end
  endfunction

  function automatic result_t tally_step(in_item_t it);
    result_t    r;
    logic [8:0] run;
    logic       low;
    logic       spike;
    int         c;
    c     = it.channel;
    spike = 1'b0;
    case (it.action)
      ACT_CLEAR: wipe_tallies();
      ACT_LOAD:  ch_thr[c] = it.threshold;
      ACT_SAMPLE: begin
        if ({1'b0, it.channel} < act_ch) begin
          if (mode == MODE_SPIKE) begin
            low = $signed(it.sample) <= $signed(ch_thr[c]);
            run = run_cnt[c];
            if (it.first_in_block) begin
              run = low ? {1'b0, run_len} : 9'd0;
            end else if (low) begin
              if (run < RUN_MAX) begin
                run = run + 9'd1;
                if (run == {1'b0, run_len}) spike = 1'b1;
              end
            end else begin
              run = 9'd0;
            end
            run_cnt[c] = run;
            if (spike && totals[c] != '1) totals[c] = totals[c] + 32'd1;
          end else begin
            if ($signed(it.sample) < $signed(ch_lo[c])) ch_lo[c] = it.sample;
            if ($signed(it.sample) > $signed(ch_hi[c])) ch_hi[c] = it.sample;
          end
        end
      end
      default: ;
    endcase
    r.spike_count = totals[c];
    r.minimum     = ch_lo[c];
    r.maximum     = ch_hi[c];
    r.spike_now   = spike;
    return r;
  endfunction

  task automatic field_check(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
      err_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode    = MODE_RESET;
      run_len = RUN_LENGTH_RESET;
      act_ch  = ACTIVE_CH_RESET;
      wipe_tallies();
      foreach (ch_thr[i]) ch_thr[i] = '0;
      expected_tallies.delete();
      err_count_o = 0;
      checked_o   = 0;
      spikes_o    = 0;
    end else begin
      if (done_i) begin
        if (expected_tallies.size() == 0) begin
          $display("%0t: result with no item outstanding, expected none, actual %h",
                   $time, result_i);
          err_count_o++;
        end else begin
          want = expected_tallies.pop_front();
          checked_o++;
          if (result_i.spike_now) spikes_o++;
          field_check("spike_count", want.spike_count, result_i.spike_count);
          field_check("minimum", want.minimum, result_i.minimum);
          field_check("maximum", want.maximum, result_i.maximum);
          field_check("spike_now", want.spike_now, result_i.spike_now);
        end
      end
      if (start_i && !busy_i) expected_tallies.push_back(tally_step(item_i));
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (paddr_i[3:2])
            REG_MODE:       mode    = pwdata_i[0];
            REG_RUN_LENGTH: run_len = pwdata_i[7:0];
            REG_ACTIVE_CH:  act_ch  = pwdata_i[9:0];
            default: ;
          endcase
        end else begin
          case (paddr_i[3:2])
            REG_MODE:       reg_val = {31'd0, mode};
            REG_RUN_LENGTH: reg_val = {24'd0, run_len};
            REG_ACTIVE_CH:  reg_val = {22'd0, act_ch};
            default:        reg_val = prdata_i;
          endcase
          field_check("register read", reg_val, prdata_i);
        end
      end
    end
    pending_o = expected_tallies.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// testbench top: clock, reset, item and register stimulus, and the verdict
`timescale 1ns / 1ps

module tb_top;
  import mspt_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  in_item_t    item    = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy;
  logic        done_o;
  result_t     result;
  logic [31:0] prdata;
  logic        pready;

  int err_count, pending, n_checked, n_spikes;
  int n_items, n_loads, n_clears, n_settings, cycles;
  int cur_act;
  bit loaded [512];
  logic signed [15:0] thr_tb [512];

  multichannel_spike_and_peak_tally u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item),
    .done_o   (done_o),
    .result_o (result),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  mspt_tally_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (item),
    .done_i      (done_o),
    .result_i    (result),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pready_i    (pready),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (n_checked),
    .spikes_o    (n_spikes)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_item_t mk(logic [1:0] a, logic [8:0] ch, logic signed [15:0] s,
                                  logic f, logic signed [15:0] t);
    in_item_t it;
    it.action         = a;
    it.channel        = ch;
    it.sample         = s;
    it.first_in_block = f;
    it.threshold      = t;
    return it;
  endfunction

  function automatic logic signed [15:0] rand_thr();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return 16'($urandom_range(0, 40000) - 20000);
    endcase
  endfunction

  // low means at or below the threshold
  function automatic logic signed [15:0] pick_sample(logic signed [15:0] thr, bit low);
    int t;
    int v;
    t = thr;
    if (low || t == 32767) begin
      v = ($urandom_range(0, 7) == 0) ? t : -32768 + int'($urandom_range(0, t + 32768));
    end else begin
      v = ($urandom_range(0, 7) == 0) ? t + 1 : t + 1 + int'($urandom_range(0, 32766 - t));
    end
    return 16'(v);
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    int       r;
    it = in_item_t'({$urandom, $urandom});
    it.action = 2'($urandom_range(0, 3));
    if (it.action == ACT_CLEAR && $urandom_range(0, 9) != 0) it.action = ACT_SAMPLE;
    r = $urandom_range(0, 3);
    if (r == 0) it.channel = 9'(cur_act - 1);
    else if (r == 1 && cur_act < 512) it.channel = 9'(cur_act);
    return it;
  endfunction

  // entered at a falling edge, leaves start high at the falling edge after the item is accepted
  task automatic send(in_item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    n_items++;
    if (it.action == ACT_LOAD) begin
      loaded[it.channel] = 1'b1;
      thr_tb[it.channel] = it.threshold;
      n_loads++;
    end
    if (it.action == ACT_CLEAR) n_clears++;
  endtask

  task automatic hold_off(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic apb_xfer(bit wr, logic [1:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic issue(in_item_t it);
    int pct;
    pct = (n_items < 600) ? 26 : (n_items < 1200) ? 70 : 0;
    if ($urandom_range(0, 199) == 0) drain();
    if ($urandom_range(0, 99) < pct) hold_off($urandom_range(1, 3));
    if (it.action == ACT_SAMPLE && !loaded[it.channel])
      send(mk(ACT_LOAD, it.channel, 16'($urandom), 1'($urandom), rand_thr()));
    send(it);
  endtask

  task automatic run_phase(bit peak, int rl, int act, int n, int low_pm, int first_pm,
                           int noise_pct, int nset);
    logic [8:0] set_ch [$];
    logic [8:0] ch;
    int         r;
    bit         low;
    drain();
    while (busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    apb_xfer(1'b1, REG_MODE, (32'($urandom) << 1) | 32'(peak));
    apb_xfer(1'b1, REG_RUN_LENGTH, (32'($urandom) << 8) | 32'(rl));
    apb_xfer(1'b1, REG_ACTIVE_CH, (32'($urandom) << 10) | 32'(act));
    apb_xfer(1'b0, REG_MODE, '0);
    apb_xfer(1'b0, REG_RUN_LENGTH, '0);
    apb_xfer(1'b0, REG_ACTIVE_CH, '0);
    cur_act = act;
    n_settings++;
    for (int i = 0; i < nset; i++) begin
      ch = 9'($urandom_range(0, act - 1));
      set_ch.push_back(ch);
      if (!loaded[ch]) issue(mk(ACT_LOAD, ch, 16'($urandom), 1'($urandom), rand_thr()));
    end
    for (int k = 0; k < n; k++) begin
      r  = $urandom_range(0, 99);
      ch = set_ch[$urandom_range(0, nset - 1)];
      if (r >= noise_pct) begin
        low = $urandom_range(0, 999) < low_pm;
        issue(mk(ACT_SAMPLE, ch, pick_sample(thr_tb[ch], low),
                 $urandom_range(0, 999) < first_pm, 16'($urandom)));
      end else begin
        case ($urandom_range(0, 3))
          0: issue(noise_item());
          1: issue(mk(ACT_LOAD, ch, 16'($urandom), 1'($urandom), rand_thr()));
          2: issue(mk(ACT_SAMPLE, ch, pick_sample(thr_tb[ch], 1'b0), 1'b0, 16'($urandom)));
          default: begin
            if ($urandom_range(0, 3) == 0)
              issue(mk(ACT_CLEAR, 9'($urandom), 16'($urandom), 1'($urandom), 16'($urandom)));
            else
              issue(noise_item());
          end
        endcase
      end
    end
  endtask

  initial begin
    cur_act = ACTIVE_CH_RESET;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: spike mode, run of 5, 384 channels
    send(mk(ACT_LOAD, 9'd0, 16'sh1234, 1'b1, 16'sd0));
    send(mk(ACT_LOAD, 9'd383, 16'sh0000, 1'b0, 16'sh8000));
    send(mk(ACT_LOAD, 9'd384, 16'shffff, 1'b1, 16'sh7fff));
    send(mk(ACT_LOAD, 9'd511, 16'sh7fff, 1'b0, 16'sd100));
    send(mk(ACT_SAMPLE, 9'd0, 16'sh8000, 1'b1, 16'sh7fff));
    send(mk(ACT_SAMPLE, 9'd0, 16'sd0, 1'b0, 16'sh0000));
    send(mk(ACT_SAMPLE, 9'd0, 16'sd1, 1'b0, 16'sh0000));
    repeat (5) send(mk(ACT_SAMPLE, 9'd0, 16'sd0, 1'b0, 16'shffff));
    send(mk(ACT_SAMPLE, 9'd0, 16'sd0, 1'b0, 16'sh0000));
    send(mk(ACT_SAMPLE, 9'd383, 16'sh8000, 1'b0, 16'sh0000));
    send(mk(ACT_SAMPLE, 9'd383, 16'sh8001, 1'b0, 16'sh0000));
    send(mk(ACT_SAMPLE, 9'd384, -16'sd100, 1'b0, 16'sh0000));
    send(mk(ACT_SAMPLE, 9'd511, 16'sh7fff, 1'b1, 16'sh0000));
    send(mk(2'd3, 9'd0, 16'sh7fff, 1'b1, 16'sh7fff));
    send(mk(ACT_CLEAR, 9'd0, 16'sh0000, 1'b0, 16'sh0000));
    send(mk(ACT_SAMPLE, 9'd0, 16'sh7fff, 1'b1, 16'sh0000));
    send(mk(ACT_LOAD, 9'd0, 16'sh0000, 1'b0, 16'sh7fff));
    send(mk(ACT_SAMPLE, 9'd0, 16'sh7fff, 1'b0, 16'sh0000));

    run_phase(1'b0,   1, 512, 220,  600,  50, 20, 6);
    run_phase(1'b1, 200, 512, 180,  500,  50, 20, 8);
    run_phase(1'b0, 255,   1, 520, 1000,   0,  0, 1);
    run_phase(1'b0, 255,   1, 150,  990,   5,  5, 1);
    run_phase(1'b0,   3, 100, 250,  800, 100, 20, 4);
    run_phase(1'b1,   5,  37, 150,  500,  50, 25, 5);
    run_phase(1'b0,   5, 384, 200,  850,  80, 20, 3);
    run_phase(1'b0,   8, 512, 120,  900,  50, 15, 2);

    drain();
    repeat (20) @(negedge clk_i);
    $display("covered %0d items (%0d threshold loads, %0d clears) across %0d register settings",
             n_items, n_loads, n_clears, n_settings);
    $display("compared %0d results, %0d of them completing a spike", n_checked, n_spikes);
    if (err_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
